/* rtl/ccs_pkg.sv */
// Shared types and constants of the comment stripper.
package ccs_pkg;

	localparam logic [2:0] MODE_NORMAL = 3'd0;
	localparam logic [2:0] MODE_BLOCK  = 3'd1;
	localparam logic [2:0] MODE_STRING = 3'd2;
	localparam logic [2:0] MODE_CHAR   = 3'd3;
	localparam logic [2:0] MODE_LINE   = 3'd4;

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_line_end;
		logic       last_of_run;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} lex_out_t;

endpackage

/* rtl/c_comment_stripper_core.sv */
// Top level of the comment stripper: lexer feeding a result queue.
//
// Input channel: in_valid/in_ready with byte_value and is_line_end; one
// item is either a source byte or a line-end marker. Output channel:
// out_valid/out_ready with out_byte, out_line_end and last_of_run; an item
// yields zero, one or two results, the final one flagged by last_of_run.
// The lexer updates its mode and held-character flags at the input
// transfer and writes its results into a four-entry queue in that cycle.
// Each result is registered in the queue and offered from its head.
// Throughput: one input item per cycle while each item gives at most one
// result and out_ready stays high; an item that gives two results holds
// the queue's single read port for two reads. in_ready is high while the queue
// has room for two results, so a stalled receiver fills the queue and
// then holds off the sender without losing or repeating anything.
// Reset clears the lexer to normal text with nothing held and empties
// the queue.
module c_comment_stripper_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_value,
	input  logic       is_line_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_line_end,
	output logic       last_of_run
);

	ccs_pkg::lex_out_t               lex_out;
	ccs_pkg::result_t                head;
	logic [ccs_pkg::QCNT_W-1:0]      count;
	logic                            take;
	logic                            pop;

	assign in_ready  = (count <= ccs_pkg::QCNT_W'(ccs_pkg::QUEUE_DEPTH - 2));
	assign take      = in_valid && in_ready;
	assign out_valid = (count != '0);
	assign pop       = out_valid && out_ready;

	assign out_byte     = head.out_byte;
	assign out_line_end = head.out_line_end;
	assign last_of_run  = head.last_of_run;

	ccs_lexer u_lexer (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.byte_value  (byte_value),
		.is_line_end (is_line_end),
		.lex_out     (lex_out)
	);

	ccs_out_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (take),
		.lex_out (lex_out),
		.pop     (pop),
		.head    (head),
		.count   (count)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= ccs_pkg::QCNT_W'(ccs_pkg::QUEUE_DEPTH))
		else $error("result queue overflow");

	a_line_end_out: assert property (@(posedge clk) disable iff (!arst_n)
		take && is_line_end |=> out_valid)
		else $error("line end transfer left no result");

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_line_end |-> last_of_run && out_byte == 8'h00)
		else $error("line end marker not final result");

	a_no_take_full: assert property (@(posedge clk) disable iff (!arst_n)
		count > ccs_pkg::QCNT_W'(ccs_pkg::QUEUE_DEPTH - 2) |-> !in_ready)
		else $error("input taken without room for two results");

endmodule

/* rtl/ccs_lexer.sv */
// Lexer state and per-item result generation.
module ccs_lexer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         byte_value,
	input  logic               is_line_end,
	output ccs_pkg::lex_out_t  lex_out
);

	logic [2:0] mode_q, mode_d;
	logic       slash_q, slash_d;
	logic       star_q, star_d;
	logic       esc_q, esc_d;
	ccs_pkg::lex_out_t lo;
	logic [7:0] close_ch;

	always_comb begin
		mode_d   = mode_q;
		slash_d  = slash_q;
		star_d   = star_q;
		esc_d    = esc_q;
		lo       = '0;
		close_ch = (mode_q == ccs_pkg::MODE_STRING) ? ccs_pkg::CH_DQUOTE : ccs_pkg::CH_SQUOTE;
		if (is_line_end) begin
			if (slash_q) begin
				lo.r0.out_byte     = ccs_pkg::CH_SLASH;
				lo.r1.out_line_end = 1'b1;
				lo.count           = 2'd2;
			end else begin
				lo.r0.out_line_end = 1'b1;
				lo.count           = 2'd1;
			end
			slash_d = 1'b0;
			star_d  = 1'b0;
			esc_d   = 1'b0;
			if (mode_q != ccs_pkg::MODE_BLOCK) begin
				mode_d = ccs_pkg::MODE_NORMAL;
			end
		end else begin
			unique case (mode_q) inside
				ccs_pkg::MODE_BLOCK: begin
					if (star_q && byte_value == ccs_pkg::CH_SLASH) begin
						mode_d         = ccs_pkg::MODE_NORMAL;
						star_d         = 1'b0;
						lo.r0.out_byte = ccs_pkg::CH_SPACE;
						lo.count       = 2'd1;
					end else begin
						star_d = (byte_value == ccs_pkg::CH_STAR);
					end
				end
				ccs_pkg::MODE_STRING, ccs_pkg::MODE_CHAR: begin
					lo.r0.out_byte = byte_value;
					lo.count       = 2'd1;
					if (esc_q) begin
						esc_d = 1'b0;
					end else if (byte_value == ccs_pkg::CH_BSLASH) begin
						esc_d = 1'b1;
					end else if (byte_value == close_ch) begin
						mode_d = ccs_pkg::MODE_NORMAL;
					end
				end
				ccs_pkg::MODE_LINE: begin
				end
				default: begin
					mode_d = ccs_pkg::MODE_NORMAL;
					if (slash_q) begin
						slash_d = 1'b0;
						if (byte_value == ccs_pkg::CH_STAR) begin
							mode_d         = ccs_pkg::MODE_BLOCK;
							star_d         = 1'b0;
							lo.r0.out_byte = ccs_pkg::CH_SPACE;
							lo.count       = 2'd1;
						end else if (byte_value == ccs_pkg::CH_SLASH) begin
							mode_d         = ccs_pkg::MODE_LINE;
							lo.r0.out_byte = ccs_pkg::CH_SPACE;
							lo.count       = 2'd1;
						end else begin
							lo.r0.out_byte = ccs_pkg::CH_SLASH;
							lo.r1.out_byte = byte_value;
							lo.count       = 2'd2;
							if (byte_value == ccs_pkg::CH_DQUOTE) begin
								mode_d = ccs_pkg::MODE_STRING;
							end else if (byte_value == ccs_pkg::CH_SQUOTE) begin
								mode_d = ccs_pkg::MODE_CHAR;
							end
						end
					end else if (byte_value == ccs_pkg::CH_SLASH) begin
						slash_d = 1'b1;
					end else begin
						lo.r0.out_byte = byte_value;
						lo.count       = 2'd1;
						if (byte_value == ccs_pkg::CH_DQUOTE) begin
							mode_d = ccs_pkg::MODE_STRING;
						end else if (byte_value == ccs_pkg::CH_SQUOTE) begin
							mode_d = ccs_pkg::MODE_CHAR;
						end
					end
				end
			endcase
		end
		lo.r0.last_of_run = (lo.count == 2'd1);
		lo.r1.last_of_run = (lo.count == 2'd2);
	end

	assign lex_out = lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= ccs_pkg::MODE_NORMAL;
			slash_q <= 1'b0;
			star_q  <= 1'b0;
			esc_q   <= 1'b0;
		end else if (take) begin
			mode_q  <= mode_d;
			slash_q <= slash_d;
			star_q  <= star_d;
			esc_q   <= esc_d;
		end
	end

endmodule

/* rtl/ccs_out_queue.sv */
// Result queue: takes up to two results per cycle, delivers at most one per cycle, on pop.
module ccs_out_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  ccs_pkg::lex_out_t          lex_out,
	input  logic                       pop,
	output ccs_pkg::result_t           head,
	output logic [ccs_pkg::QCNT_W-1:0] count
);

	ccs_pkg::result_t                mem [ccs_pkg::QUEUE_DEPTH];
	logic [ccs_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q, wr_ptr1;
	logic [ccs_pkg::QCNT_W-1:0]      count_q, push_n;

	assign push_n  = push ? ccs_pkg::QCNT_W'(lex_out.count) : '0;
	assign wr_ptr1 = wr_ptr_q + ccs_pkg::QPTR_W'(1);
	assign head    = mem[rd_ptr_q];
	assign count   = count_q;

	always_ff @(posedge clk) begin
		if (push && lex_out.count != 2'd0) begin
			mem[wr_ptr_q] <= lex_out.r0;
		end
		if (push && lex_out.count == 2'd2) begin
			mem[wr_ptr1] <= lex_out.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + ccs_pkg::QPTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ccs_pkg::QPTR_W'(1);
			end
			count_q <= count_q + push_n - (pop ? ccs_pkg::QCNT_W'(1) : '0);
		end
	end

endmodule

/* dv/testbench.sv */
// Testbench for c_comment_stripper_core: random and directed source text, self-checking.
`timescale 1ns / 100ps

module testbench;

	localparam int STALL_LIMIT = 1000;
	localparam int TAIL_CYCLES = 8;
	localparam int TARGET_ITEMS = 400;

	class stripper_scoreboard;
		logic [2:0]        lex_mode;
		bit                slash_pending;
		bit                star_seen;
		bit                escape_pending;
		ccs_pkg::result_t  batch[$];
		ccs_pkg::result_t  stripped_q[$];
		int                errors;

		function new();
			lex_mode = ccs_pkg::MODE_NORMAL;
			slash_pending = 1'b0;
			star_seen = 1'b0;
			escape_pending = 1'b0;
			errors = 0;
		endfunction

		function int pending();
			return stripped_q.size();
		endfunction

		function void push_char(logic [7:0] b, logic le);
			ccs_pkg::result_t r;
			r.out_byte = b;
			r.out_line_end = le;
			r.last_of_run = 1'b0;
			batch = {batch, r};
		endfunction

		function void plain_text(logic [7:0] b);
			if (b == ccs_pkg::CH_SLASH) begin
				slash_pending = 1'b1;
			end else begin
				if (b == ccs_pkg::CH_DQUOTE)
					lex_mode = ccs_pkg::MODE_STRING;
				else if (b == ccs_pkg::CH_SQUOTE)
					lex_mode = ccs_pkg::MODE_CHAR;
				push_char(b, 1'b0);
			end
		endfunction

		function int take_source(logic [7:0] b, logic le);
			int n;
			batch.delete();
			if (le) begin
				if (slash_pending)
					push_char(ccs_pkg::CH_SLASH, 1'b0);
				push_char(8'h00, 1'b1);
				slash_pending = 1'b0;
				star_seen = 1'b0;
				escape_pending = 1'b0;
				if (lex_mode != ccs_pkg::MODE_BLOCK)
					lex_mode = ccs_pkg::MODE_NORMAL;
			end else begin
				case (lex_mode)
					ccs_pkg::MODE_BLOCK: begin
						if (star_seen && b == ccs_pkg::CH_SLASH) begin
							lex_mode = ccs_pkg::MODE_NORMAL;
							star_seen = 1'b0;
							push_char(ccs_pkg::CH_SPACE, 1'b0);
						end else begin
							star_seen = (b == ccs_pkg::CH_STAR);
						end
					end
					ccs_pkg::MODE_STRING, ccs_pkg::MODE_CHAR: begin
						push_char(b, 1'b0);
						if (escape_pending)
							escape_pending = 1'b0;
						else if (b == ccs_pkg::CH_BSLASH)
							escape_pending = 1'b1;
						else if ((lex_mode == ccs_pkg::MODE_STRING && b == ccs_pkg::CH_DQUOTE) ||
								(lex_mode == ccs_pkg::MODE_CHAR && b == ccs_pkg::CH_SQUOTE))
							lex_mode = ccs_pkg::MODE_NORMAL;
					end
					ccs_pkg::MODE_LINE: begin
					end
					default: begin
						lex_mode = ccs_pkg::MODE_NORMAL;
						if (slash_pending) begin
							slash_pending = 1'b0;
							if (b == ccs_pkg::CH_STAR) begin
								lex_mode = ccs_pkg::MODE_BLOCK;
								star_seen = 1'b0;
								push_char(ccs_pkg::CH_SPACE, 1'b0);
							end else if (b == ccs_pkg::CH_SLASH) begin
								lex_mode = ccs_pkg::MODE_LINE;
								push_char(ccs_pkg::CH_SPACE, 1'b0);
							end else begin
								push_char(ccs_pkg::CH_SLASH, 1'b0);
								plain_text(b);
							end
						end else begin
							plain_text(b);
						end
					end
				endcase
			end
			n = batch.size();
			if (n > 0)
				batch[n - 1].last_of_run = 1'b1;
			stripped_q = {stripped_q, batch};
			return n;
		endfunction

		task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
			errors++;
			$display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
		endtask

		task check_stripped(logic [7:0] b, logic le, logic last);
			ccs_pkg::result_t want;
			if (stripped_q.size() == 0) begin
				report_mismatch("unexpected result", b, 8'h00);
				return;
			end
			want = stripped_q.pop_front();
			if (b !== want.out_byte)
				report_mismatch("out_byte", b, want.out_byte);
			if (le !== want.out_line_end)
				report_mismatch("out_line_end", {7'd0, le}, {7'd0, want.out_line_end});
			if (last !== want.last_of_run)
				report_mismatch("last_of_run", {7'd0, last}, {7'd0, want.last_of_run});
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] byte_value = 8'h00;
	logic       is_line_end = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       out_line_end;
	logic       last_of_run;

	stripper_scoreboard sb;
	int burst_left = 0;
	int accepted_items = 0;
	bit hold_request = 1'b0;

	c_comment_stripper_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.byte_value  (byte_value),
		.is_line_end (is_line_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.out_line_end(out_line_end),
		.last_of_run (last_of_run)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				void'(sb.take_source(byte_value, is_line_end));
				accepted_items++;
			end
			if (out_valid && out_ready)
				sb.check_stripped(out_byte, out_line_end, last_of_run);
		end
	end

	initial begin : receiver
		int hold_left;
		int run_left;
		int style;
		hold_left = 0;
		run_left = 0;
		style = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 60;
				out_ready <= 1'b0;
			end else begin
				if (run_left == 0) begin
					style = $urandom_range(0, 3);
					run_left = $urandom_range(4, 50);
				end
				run_left--;
				case (style)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= ($urandom_range(0, 1) != 0);
					default: out_ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("testbench failed");
		$finish;
	end

	task automatic send_item(input logic [7:0] b, input logic le);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		byte_value <= b;
		is_line_end <= le;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_line(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic logic [7:0] lex_byte();
		case ($urandom_range(0, 9))
			0: return ccs_pkg::CH_STAR;
			1: return ccs_pkg::CH_SLASH;
			2: return ccs_pkg::CH_BSLASH;
			3: return ccs_pkg::CH_DQUOTE;
			4: return ccs_pkg::CH_SQUOTE;
			5: return ccs_pkg::CH_SPACE;
			default: return 8'($urandom_range(8'h20, 8'h7E));
		endcase
	endfunction

	task automatic send_chunk();
		int kind;
		int len;
		kind = $urandom_range(0, 15);
		len = $urandom_range(1, 8);
		case (kind)
			0, 1, 2: repeat (len) send_item(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
			3, 4: begin
				send_item(ccs_pkg::CH_DQUOTE, 1'b0);
				repeat (len) begin
					if ($urandom_range(0, 4) == 0) begin
						send_item(ccs_pkg::CH_BSLASH, 1'b0);
						send_item(lex_byte(), 1'b0);
					end else begin
						send_item(lex_byte(), 1'b0);
					end
				end
				send_item(ccs_pkg::CH_DQUOTE, 1'b0);
			end
			5: begin
				send_item(ccs_pkg::CH_SQUOTE, 1'b0);
				if ($urandom_range(0, 2) == 0)
					send_item(ccs_pkg::CH_BSLASH, 1'b0);
				send_item(lex_byte(), 1'b0);
				send_item(ccs_pkg::CH_SQUOTE, 1'b0);
			end
			6, 7: begin
				send_item(ccs_pkg::CH_SLASH, 1'b0);
				send_item(ccs_pkg::CH_STAR, 1'b0);
				repeat (len) begin
					if ($urandom_range(0, 6) == 0)
						send_item(8'($urandom_range(0, 255)), 1'b1);
					else
						send_item(lex_byte(), 1'b0);
				end
				send_item(ccs_pkg::CH_STAR, 1'b0);
				send_item(ccs_pkg::CH_SLASH, 1'b0);
			end
			8: begin
				send_item(ccs_pkg::CH_SLASH, 1'b0);
				send_item(ccs_pkg::CH_SLASH, 1'b0);
				repeat (len) send_item(lex_byte(), 1'b0);
				send_item(8'($urandom_range(0, 255)), 1'b1);
			end
			9, 10: send_item(8'($urandom_range(0, 255)), 1'b1);
			11, 12: repeat (len) send_item(8'($urandom_range(0, 255)), 1'b0);
			13: begin
				send_item(ccs_pkg::CH_SLASH, 1'b0);
				send_item(lex_byte(), 1'b0);
			end
			default: repeat (len) send_item(lex_byte(), 1'b0);
		endcase
	endtask

	initial begin : stimulus
		int next_drain;
		bit hold_done;
		next_drain = 100;
		hold_done = 1'b0;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_line("/b/");
		send_line("/*/*");
		send_line("/*/y");
		send_line("//z");
		send_line("\"\\\"\"'\\''");
		wait_for_drain();

		while (accepted_items < TARGET_ITEMS) begin
			send_chunk();
			if (!hold_done && accepted_items >= 150) begin
				hold_request = 1'b1;
				burst_left = 60;
				hold_done = 1'b1;
			end
			if (accepted_items >= next_drain) begin
				wait_for_drain();
				next_drain += 100;
			end
		end

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
